// File: hw/rtl/hcw_pkg.sv
// Shared types and constants for the histogram coverage window block.
package hcw_pkg;

    // Coverage target in basis points
    localparam int                TGT_W        = 14;
    localparam logic [TGT_W-1:0]  TARGET_RESET = 14'd6827;

    // Basis-point scale used in the cross-multiplied coverage tests
    localparam int                BP_W         = 14;
    localparam logic [BP_W-1:0]   BP_SCALE     = 14'd10000;

    // Fixed port field widths
    localparam int                IN_W         = 16;
    localparam int                IDX_OUT_W    = 8;
    localparam int                SUM_OUT_W    = 24;

    // Load side to search side events
    typedef struct packed {
        logic launch;   // last bin beat accepted this cycle
        logic empty;    // running total is zero
    } t_load_evt;

    // Search side status back to the load side and the port
    typedef struct packed {
        logic busy;     // search in progress
        logic clear;    // drop load state for the next histogram
    } t_search_evt;

endpackage

// File: hw/rtl/hcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module hcw_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/hcw_loader.sv
// Bin loader: stores bins, keeps the running total, first peak and bin count.
module hcw_loader #(
    parameter  int NUM_BINS = 256,
    parameter  int CW       = 16,
    localparam int IDX_W    = $clog2(NUM_BINS),
    localparam int CNT_W    = $clog2(NUM_BINS + 1),
    localparam int TW       = CW + IDX_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [hcw_pkg::IN_W-1:0] i_bin_count,
    input  logic                    i_last_bin,
    input  hcw_pkg::t_search_evt    i_search,
    output logic                    o_we,
    output logic [IDX_W-1:0]        o_waddr,
    output logic [CW-1:0]           o_wdata,
    output logic [TW-1:0]           o_total,
    output logic [CW-1:0]           o_peak_val,
    output logic [IDX_W-1:0]        o_peak_idx,
    output logic [CNT_W-1:0]        o_count,
    output hcw_pkg::t_load_evt      o_evt
);
    import hcw_pkg::*;

    logic [CNT_W-1:0]     r_count;
    logic [TW-1:0]        r_total;
    logic [CW-1:0]        r_peak_val;
    logic [IDX_W-1:0]     r_peak_idx;
    logic [CW+IN_W-1:0]   cnt_ext;
    logic [CW-1:0]        cnt;
    logic                 room;

    // Keep only the configured count bits of the beat
    assign cnt_ext = (CW + IN_W)'(i_bin_count);
    assign cnt     = cnt_ext[CW-1:0];
    assign room    = r_count < CNT_W'(NUM_BINS);

    assign o_we    = i_accept && room;
    assign o_waddr = r_count[IDX_W-1:0];
    assign o_wdata = cnt;

    // Accumulate total and first maximum; drop bins beyond capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_search.clear) begin
            r_count    <= '0;
            r_total    <= '0;
            r_peak_val <= '0;
            r_peak_idx <= '0;
        end else if (i_accept && room) begin
            r_count <= r_count + CNT_W'(1);
            r_total <= r_total + TW'(cnt);
            if (cnt > r_peak_val) begin
                r_peak_val <= cnt;
                r_peak_idx <= r_count[IDX_W-1:0];
            end
        end
    end

    assign o_total    = r_total;
    assign o_peak_val = r_peak_val;
    assign o_peak_idx = r_peak_idx;
    assign o_count    = r_count;

    assign o_evt.launch = i_accept && i_last_bin;
    assign o_evt.empty  = (r_total == '0);

endmodule

// File: hw/rtl/hcw_search.sv
// Window search: grows the window from the peak over the bin memory, emits the result.
module hcw_search #(
    parameter  int NUM_BINS = 256,
    parameter  int CW       = 16,
    localparam int IDX_W    = $clog2(NUM_BINS),
    localparam int CNT_W    = $clog2(NUM_BINS + 1),
    localparam int TW       = CW + IDX_W,
    localparam int SW       = TW + hcw_pkg::BP_W,
    localparam int XW       = CW + hcw_pkg::BP_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcw_pkg::t_load_evt            i_load,
    input  logic [TW-1:0]                 i_total,
    input  logic [CW-1:0]                 i_peak_val,
    input  logic [IDX_W-1:0]              i_peak_idx,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [hcw_pkg::TGT_W-1:0]     i_target,
    output logic [IDX_W-1:0]              o_raddr,
    input  logic [CW-1:0]                 i_rdata,
    output hcw_pkg::t_search_evt          o_ctl,
    output logic                          o_valid,
    output logic [hcw_pkg::IDX_OUT_W-1:0] o_left_bin,
    output logic [hcw_pkg::IDX_OUT_W-1:0] o_right_bin,
    output logic [hcw_pkg::SUM_OUT_W-1:0] o_window_sum,
    output logic [hcw_pkg::SUM_OUT_W-1:0] o_total_sum,
    output logic                          o_empty_histogram
);
    import hcw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GOAL,
        S_GAP,
        S_READ,
        S_SCALE,
        S_EVAL
    } t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_left;
    logic [IDX_W-1:0]      r_right;
    logic [TW-1:0]         r_win;
    logic [SW-1:0]         r_goal;
    logic [SW-1:0]         r_peak_sc;
    logic signed [SW:0]    r_gap;
    logic [CW-1:0]         r_lval;
    logic [CW-1:0]         r_rval;
    logic [XW-1:0]         r_lsc;
    logic [XW-1:0]         r_rsc;
    logic                  r_side;     // 0: left neighbor, 1: right neighbor
    logic                  r_init;     // fetching both neighbors of the peak
    logic                  r_valid;
    logic [IDX_OUT_W-1:0]  r_out_left;
    logic [IDX_OUT_W-1:0]  r_out_right;
    logic [SUM_OUT_W-1:0]  r_out_win;
    logic [SUM_OUT_W-1:0]  r_out_total;
    logic                  r_out_empty;

    logic [SW-1:0]         goal_prod;
    logic [SW-1:0]         peak_prod;
    logic [XW-1:0]         rd_prod;
    logic                  can_l;
    logic                  can_r;
    logic                  can_r2;
    logic                  go_left;
    logic [XW-1:0]         sel_sc;
    logic [CW-1:0]         sel_val;
    logic                  take;
    logic                  stop;
    logic                  finish;
    logic [IDX_W-1:0]      fin_left;
    logic [IDX_W-1:0]      fin_right;
    logic [TW-1:0]         fin_win;
    logic [IDX_W+IDX_OUT_W-1:0] left_ext;
    logic [IDX_W+IDX_OUT_W-1:0] right_ext;
    logic [TW+SUM_OUT_W-1:0]    win_ext;
    logic [TW+SUM_OUT_W-1:0]    total_ext;

    // Scale products, each registered before use
    assign goal_prod = SW'(i_target) * SW'(i_total);
    assign peak_prod = SW'(i_peak_val) * SW'(BP_SCALE);
    assign rd_prod   = XW'(i_rdata) * XW'(BP_SCALE);

    // Neighbor availability and growth decision
    always_comb begin
        can_l   = (r_left != '0);
        can_r   = (CNT_W'(r_right) + CNT_W'(1)) < i_count;
        can_r2  = (CNT_W'(r_right) + CNT_W'(2)) < i_count;
        go_left = (can_l && can_r) ? (r_lval > r_rval) : can_l;
        sel_sc  = go_left ? r_lsc : r_rsc;
        sel_val = go_left ? r_lval : r_rval;
        // closer to the goal iff 0 < step < 2 * gap, gap known positive here
        take    = (sel_sc != '0) && ((SW + 1)'(sel_sc) < {r_gap[SW-1:0], 1'b0});
        stop    = (r_gap <= 0) || (!can_l && !can_r) || !take;
        finish  = ((r_state == S_GOAL) && i_load.empty) || ((r_state == S_EVAL) && stop);
    end

    // Read the neighbor on the fetch side
    assign o_raddr = r_side ? (r_right + IDX_W'(1)) : (r_left - IDX_W'(1));

    // Result fields, empty histogram reports bin 0 alone
    always_comb begin
        fin_left  = (r_state == S_GOAL) ? '0 : r_left;
        fin_right = (r_state == S_GOAL) ? '0 : r_right;
        fin_win   = (r_state == S_GOAL) ? '0 : r_win;
        left_ext  = (IDX_W + IDX_OUT_W)'(fin_left);
        right_ext = (IDX_W + IDX_OUT_W)'(fin_right);
        win_ext   = (TW + SUM_OUT_W)'(fin_win);
        total_ext = (TW + SUM_OUT_W)'(i_total);
    end

    // Search sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_side  <= 1'b0;
            r_init  <= 1'b0;
        end else begin
            r_valid <= finish;
            if (finish) begin
                r_out_left  <= left_ext[IDX_OUT_W-1:0];
                r_out_right <= right_ext[IDX_OUT_W-1:0];
                r_out_win   <= win_ext[SUM_OUT_W-1:0];
                r_out_total <= total_ext[SUM_OUT_W-1:0];
                r_out_empty <= (r_state == S_GOAL);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_load.launch) begin
                        r_state <= S_GOAL;
                    end
                end
                S_GOAL: begin
                    r_goal    <= goal_prod;
                    r_peak_sc <= peak_prod;
                    r_win     <= TW'(i_peak_val);
                    r_left    <= i_peak_idx;
                    r_right   <= i_peak_idx;
                    r_state   <= i_load.empty ? S_IDLE : S_GAP;
                end
                S_GAP: begin
                    r_gap <= $signed({1'b0, r_goal}) - $signed({1'b0, r_peak_sc});
                    if (can_l) begin
                        r_side  <= 1'b0;
                        r_init  <= 1'b1;
                        r_state <= S_READ;
                    end else if (can_r) begin
                        r_side  <= 1'b1;
                        r_init  <= 1'b0;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_READ: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_side) begin
                        r_rval <= i_rdata;
                        r_rsc  <= rd_prod;
                    end else begin
                        r_lval <= i_rdata;
                        r_lsc  <= rd_prod;
                    end
                    r_init <= 1'b0;
                    if (r_init && can_r) begin
                        r_side  <= 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (stop) begin
                        r_state <= S_IDLE;
                    end else begin
                        // take the step, then refill that side if it has a bin left
                        r_win <= r_win + TW'(sel_val);
                        r_gap <= r_gap - $signed((SW + 1)'(sel_sc));
                        if (go_left) begin
                            r_left  <= r_left - IDX_W'(1);
                            r_side  <= 1'b0;
                            r_state <= (r_left != IDX_W'(1)) ? S_READ : S_EVAL;
                        end else begin
                            r_right <= r_right + IDX_W'(1);
                            r_side  <= 1'b1;
                            r_state <= can_r2 ? S_READ : S_EVAL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ctl.busy        = (r_state != S_IDLE);
    assign o_ctl.clear       = finish;
    assign o_valid           = r_valid;
    assign o_left_bin        = r_out_left;
    assign o_right_bin       = r_out_right;
    assign o_window_sum      = r_out_win;
    assign o_total_sum       = r_out_total;
    assign o_empty_histogram = r_out_empty;

endmodule

// File: hw/rtl/histogram_coverage_window_top.sv
// Top level of the histogram coverage window: bin memory, loader and window search.
//
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------------
// bin in    input      start && !busy         i_bin_count, i_last_bin
// result    output     o_valid, one cycle     o_left_bin, o_right_bin, o_window_sum,
//                                             o_total_sum, o_empty_histogram
// config    input      i_cfg_we               i_cfg_wdata (target in basis points)
//
// Bins load at one beat per cycle; busy stays low while loading.
// The last bin beat starts the search: an empty histogram holds busy only for goal setup;
// otherwise busy holds through setup and final check, a read and scale per initial neighbor
// fetch, and an evaluation, read and scale per growth step that refills a neighbor (the
// evaluation alone once that side is used up), all through the bin memory's single read port.
// The result strobes in the first cycle with busy low; the next histogram may load then.
// Synchronous active-low reset clears load state and sets the target to 6827 bp.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module histogram_coverage_window_top #(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hcw_pkg::IN_W-1:0]      i_bin_count,
    input  logic                          i_last_bin,
    input  logic                          i_cfg_we,
    input  logic [hcw_pkg::TGT_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output logic [hcw_pkg::IDX_OUT_W-1:0] o_left_bin,
    output logic [hcw_pkg::IDX_OUT_W-1:0] o_right_bin,
    output logic [hcw_pkg::SUM_OUT_W-1:0] o_window_sum,
    output logic [hcw_pkg::SUM_OUT_W-1:0] o_total_sum,
    output logic                          o_empty_histogram
);
    import hcw_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(NUM_BINS + 1);
    localparam int TW    = COUNT_BITS + IDX_W;

    logic [TGT_W-1:0]      r_target;
    logic                  accept;
    t_load_evt             load_evt;
    t_search_evt           search_evt;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
    logic [COUNT_BITS-1:0] rdata;
    logic [TW-1:0]         total;
    logic [COUNT_BITS-1:0] peak_val;
    logic [IDX_W-1:0]      peak_idx;
    logic [CNT_W-1:0]      count;

    // Hold the coverage target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    assign accept = start && !search_evt.busy;
    assign busy   = search_evt.busy;

    hcw_loader #(
        .NUM_BINS (NUM_BINS),
        .CW       (COUNT_BITS)
    ) u_loader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bin_count (i_bin_count),
        .i_last_bin  (i_last_bin),
        .i_search    (search_evt),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_total     (total),
        .o_peak_val  (peak_val),
        .o_peak_idx  (peak_idx),
        .o_count     (count),
        .o_evt       (load_evt)
    );

    hcw_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hcw_search #(
        .NUM_BINS (NUM_BINS),
        .CW       (COUNT_BITS)
    ) u_search (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load_evt),
        .i_total           (total),
        .i_peak_val        (peak_val),
        .i_peak_idx        (peak_idx),
        .i_count           (count),
        .i_target          (r_target),
        .o_raddr           (raddr),
        .i_rdata           (rdata),
        .o_ctl             (search_evt),
        .o_valid           (o_valid),
        .o_left_bin        (o_left_bin),
        .o_right_bin       (o_right_bin),
        .o_window_sum      (o_window_sum),
        .o_total_sum       (o_total_sum),
        .o_empty_histogram (o_empty_histogram)
    );

    // A last bin beat always starts a search
    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_bin) |=> busy)
        else $error("search did not start after last bin beat");

    // A result follows the end of a search
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished search");

    // An empty histogram reports bin 0 alone with zero sums
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_histogram) |->
            (o_left_bin == '0 && o_right_bin == '0 &&
             o_window_sum == '0 && o_total_sum == '0))
        else $error("empty histogram result is not bin 0 with zero sums");

endmodule
